@@ rtl/tpc_pkg.sv @@
`timescale 1ns / 1ps
package tpc_pkg;

    typedef enum logic [2:0] {
        DEPTH_NONE,
        DEPTH_32,
        DEPTH_24,
        DEPTH_16,
        DEPTH_8,
        DEPTH_4
    } depth_t;

    typedef enum logic [1:0] {
        KIND_PALETTE = 2'd0,
        KIND_COLOR   = 2'd1,
        KIND_INDEX   = 2'd2
    } kind_t;

    typedef enum logic {
        OP_PALETTE = 1'b0,
        OP_IMAGE   = 1'b1
    } op_t;

    localparam logic [7:0] FMT_RGBA32    = 8'h00;
    localparam logic [7:0] FMT_RGB24     = 8'h01;
    localparam logic [7:0] FMT_RGB555_A  = 8'h02;
    localparam logic [7:0] FMT_RGB555_B  = 8'h0A;
    localparam logic [7:0] FMT_IDX8_A    = 8'h13;
    localparam logic [7:0] FMT_IDX8_B    = 8'h1B;
    localparam logic [7:0] FMT_IDX4_A    = 8'h14;
    localparam logic [7:0] FMT_IDX4_B    = 8'h24;
    localparam logic [7:0] FMT_IDX4_C    = 8'h2C;

    localparam logic [7:0] ALPHA_SAT     = 8'h7F;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] color_index;
        logic [7:0] palette_address;
        logic       last;
        logic       error;
    } result_t;

    function automatic depth_t depth_class(input logic [7:0] code);
        depth_t d;
        unique case (code) inside
            FMT_RGBA32:                           d = DEPTH_32;
            FMT_RGB24:                            d = DEPTH_24;
            FMT_RGB555_A, FMT_RGB555_B:           d = DEPTH_16;
            FMT_IDX8_A, FMT_IDX8_B:               d = DEPTH_8;
            FMT_IDX4_A, FMT_IDX4_B, FMT_IDX4_C:   d = DEPTH_4;
            default:                              d = DEPTH_NONE;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/texture_palette_pixel_converter.sv @@
`timescale 1ns / 1ps
// Converts palette entries and image elements into RGBA8888 colors or palette
// indices, following the pixel format and palette format registers. Each
// accepted transfer is held in an input register and converted combinationally
// into an output register, from which its result is presented on the result
// stream. A new transfer is taken every cycle while the result stream is not
// stalled; a 4-bit indexed image element stays in the input register until
// both of its nibble results have moved on, so in that format a new transfer
// is taken only after the high nibble result. Write the format registers only
// while the block is idle; writes do not reset the palette entry counter.
module texture_palette_pixel_converter (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] data
    input  logic        s_tuser,    // [0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // red, green, blue, alpha, color_index,
                                    // palette_address, error, zero pad
    output logic [1:0]  m_tuser,    // [1:0] kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tpc_pkg::*;

    logic [7:0] pixel_format_reg;
    logic [7:0] clut_format_reg;
    logic [7:0] palette_counter_reg;

    logic        in_valid_reg;
    logic        half_reg;
    logic        op_reg;
    logic [31:0] data_reg;

    logic        out_valid_reg;
    result_t     out_reg;

    result_t     res_next;
    logic [7:0]  counter_next;
    logic        two_results;
    logic        out_free;
    logic        advance;
    logic        finishing;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {24'h0, clut_format_reg} : {24'h0, pixel_format_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_format_reg <= '0;
            clut_format_reg  <= '0;
        end else if (cfg_write) begin
            if (paddr[2]) begin
                clut_format_reg <= pwdata[7:0];
            end else begin
                pixel_format_reg <= pwdata[7:0];
            end
        end
    end

    tpc_convert u_convert (
        .op              (op_reg),
        .data            (data_reg),
        .second_half     (half_reg),
        .pixel_format    (pixel_format_reg),
        .clut_format     (clut_format_reg),
        .palette_counter (palette_counter_reg),
        .res             (res_next),
        .counter_next    (counter_next),
        .two_results     (two_results)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign finishing = !two_results || half_reg;
    assign s_tready  = !in_valid_reg || (advance && finishing);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            half_reg            <= 1'b0;
            palette_counter_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                half_reg     <= 1'b0;
            end else if (advance && finishing) begin
                in_valid_reg <= 1'b0;
                half_reg     <= 1'b0;
            end else if (advance) begin
                half_reg <= 1'b1;
            end
            if (advance) begin
                palette_counter_reg <= counter_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg   <= s_tuser;
            data_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'h00, out_reg.error, out_reg.palette_address, out_reg.color_index,
                       out_reg.alpha, out_reg.blue, out_reg.green, out_reg.red};

`ifndef SYNTHESIS
    // the second nibble pass only exists while an item is held
    a_half_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> in_valid_reg)
        else $error("second nibble pass without a held item");

    // no new transfer while the held item cannot move on
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while held item is stalled");

    // error results always close their item
    a_error_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[48]) |-> m_tlast)
        else $error("error result without last");

    // a 4-bit palette entry keeps the counter within 16 entries
    a_idx4_counter: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (op_reg == OP_PALETTE) && !res_next.error
         && (depth_class(pixel_format_reg) == DEPTH_4))
        |=> (palette_counter_reg[7:4] == 4'h0))
        else $error("palette counter escaped 4-bit range");
`endif

endmodule

@@ rtl/tpc_convert.sv @@
`timescale 1ns / 1ps
module tpc_convert (
    input  logic              op,
    input  logic [31:0]       data,
    input  logic              second_half,
    input  logic [7:0]        pixel_format,
    input  logic [7:0]        clut_format,
    input  logic [7:0]        palette_counter,
    output tpc_pkg::result_t  res,
    output logic [7:0]        counter_next,
    output logic              two_results
);
    import tpc_pkg::*;

    function automatic logic [7:0] expand_alpha(input logic [7:0] a);
        logic [15:0] prod;
        prod = {a, 8'h00} - {8'h00, a};
        if (a >= ALPHA_SAT) begin
            return 8'hFF;
        end
        return prod[14:7];
    endfunction

    depth_t     depth;
    logic       pal_fmt32;
    logic       pal_fmt16;
    logic [7:0] num;

    assign depth     = depth_class(pixel_format);
    assign pal_fmt32 = (clut_format == FMT_RGBA32);
    assign pal_fmt16 = (clut_format == FMT_RGB555_A) || (clut_format == FMT_RGB555_B);
    assign num       = (depth == DEPTH_8) ? palette_counter : {4'h0, palette_counter[3:0]};

    always_comb begin
        res          = '0;
        res.last     = 1'b1;
        counter_next = palette_counter;
        two_results  = 1'b0;
        if (op == OP_PALETTE) begin
            res.kind = KIND_PALETTE;
            if (((depth != DEPTH_8) && (depth != DEPTH_4)) || !(pal_fmt32 || pal_fmt16)) begin
                res.error = 1'b1;
            end else begin
                if (depth == DEPTH_8) begin
                    // clut swizzle: swap address bits 3 and 4
                    res.palette_address = {num[7:5], num[3], num[4], num[2:0]};
                    counter_next        = num + 8'd1;
                end else begin
                    res.palette_address = num;
                    counter_next        = {4'h0, num[3:0] + 4'd1};
                end
                if (pal_fmt32) begin
                    res.red   = data[7:0];
                    res.green = data[15:8];
                    res.blue  = data[23:16];
                    res.alpha = expand_alpha(data[31:24]);
                end else begin
                    res.red   = {data[4:0], 3'b000};
                    res.green = {data[9:5], 3'b000};
                    res.blue  = {data[14:10], 3'b000};
                    res.alpha = (num == 8'd0) ? 8'h00 : 8'hFF;
                end
            end
        end else begin
            unique case (depth)
                DEPTH_32: begin
                    res.kind  = KIND_COLOR;
                    res.red   = data[7:0];
                    res.green = data[15:8];
                    res.blue  = data[23:16];
                    res.alpha = expand_alpha(data[31:24]);
                end
                DEPTH_24: begin
                    res.kind  = KIND_COLOR;
                    res.red   = data[7:0];
                    res.green = data[15:8];
                    res.blue  = data[23:16];
                    res.alpha = 8'hFF;
                end
                DEPTH_16: begin
                    res.kind  = KIND_COLOR;
                    res.red   = {data[4:0], 3'b000};
                    res.green = {data[9:5], 3'b000};
                    res.blue  = {data[14:10], 3'b000};
                    res.alpha = 8'hFF;
                end
                DEPTH_8: begin
                    res.kind        = KIND_INDEX;
                    res.color_index = data[7:0];
                end
                DEPTH_4: begin
                    // low nibble first, last only on the high nibble
                    two_results     = 1'b1;
                    res.kind        = KIND_INDEX;
                    res.color_index = second_half ? {4'h0, data[7:4]} : {4'h0, data[3:0]};
                    res.last        = second_half;
                end
                default: begin
                    res.kind  = KIND_COLOR;
                    res.error = 1'b1;
                end
            endcase
        end
    end

endmodule
